>>> hw/rtl/simon_32_64_block_cipher_assert.svh
// Assertion macros for the Simon 32/64 cipher core.
// No dependencies; included by simon_32_64_block_cipher.sv.
`ifndef SIMON_32_64_BLOCK_CIPHER_ASSERT_SVH
`define SIMON_32_64_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SIMON_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("simon core assertion failed");
`define SIMON_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("simon core assertion failed");
`else
`define SIMON_ASSERT(lbl, prop)
`define SIMON_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/simon_pkg.sv
// Types, constants and round functions for the Simon 32/64 cipher core.
// No dependencies.
package simon_pkg;

    localparam int WORD_BITS    = 16;
    localparam int ROUNDS       = 32;
    localparam int RND_IDX_BITS = 5;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [WORD_BITS-1:0]    word_t;
    typedef logic [RND_IDX_BITS-1:0] rnd_idx_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t KEY_IDX_0 = 2'd0;
    localparam cfg_idx_t KEY_IDX_1 = 2'd1;
    localparam cfg_idx_t KEY_IDX_2 = 2'd2;
    localparam cfg_idx_t KEY_IDX_3 = 2'd3;

    localparam logic [61:0] Z0_SEQ      = 62'h19C3522FB386A45F;
    localparam word_t       ROUND_CONST = 16'h0003;
    localparam rnd_idx_t    LAST_RND    = 5'd31;

    function automatic word_t round_f(input word_t x);
        word_t r1;
        word_t r8;
        word_t r2;
        r1 = {x[14:0], x[15]};
        r8 = {x[7:0], x[15:8]};
        r2 = {x[13:0], x[15:14]};
        return (r1 & r8) ^ r2;
    endfunction

    // k[i] from k[i-4], k[i-3], k[i-1] and z0 bit
    function automatic word_t key_next(input word_t km4, input word_t km3,
                                       input word_t km1, input logic zb);
        word_t t;
        t = {km1[2:0], km1[15:3]} ^ km3;
        t = t ^ {t[0], t[15:1]};
        return ~km4 ^ t ^ {{(WORD_BITS-1){1'b0}}, zb} ^ ROUND_CONST;
    endfunction

endpackage

>>> hw/rtl/simon_32_64_block_cipher.sv
// Simon 32/64 block cipher core: key expansion into a round key memory and
// a one-round-per-cycle Feistel datapath. Depends on simon_pkg and
// simon_32_64_block_cipher_assert.svh.
//
//  channel  direction  signals                                     transfer
//  s_       in         s_cmd, s_block_upper, s_block_lower         s_valid & s_ready
//  m_       out        m_result_upper, m_result_lower              m_valid & m_ready
//  cfg_     in         cfg_addr, cfg_wr_data                       cfg_wr_en
//
// An item is accepted, then runs 32 rounds with one round key memory read per
// round; the result lands in an output register.
// After reset or a key write, key expansion (window load, then one round key
// written per cycle) runs before s_ready rises.
// A stalled output holds the last round until the output register frees.
`include "simon_32_64_block_cipher_assert.svh"

module simon_32_64_block_cipher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  simon_pkg::cfg_idx_t   cfg_addr,
    input  simon_pkg::word_t      cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  simon_pkg::word_t      s_block_upper,
    input  simon_pkg::word_t      s_block_lower,
    output logic                  m_valid,
    input  logic                  m_ready,
    output simon_pkg::word_t      m_result_upper,
    output simon_pkg::word_t      m_result_lower
);
    import simon_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXPAND = 3'b010,
        ST_RUN    = 3'b100
    } state_t;

    state_t   state_reg, state_next;
    rnd_idx_t cnt_reg, cnt_next;
    logic     keys_ready_reg, keys_ready_next;
    logic     cmd_reg, cmd_next;
    logic     m_valid_reg, m_valid_next;

    word_t key_reg [4];
    word_t win_reg [4];
    word_t win_next [4];
    word_t x_reg, x_next, y_reg, y_next;
    word_t out_x_reg, out_x_next, out_y_reg, out_y_next;

    word_t    rk_mem [ROUNDS];
    word_t    rk_rdata;
    rnd_idx_t rd_addr;
    logic     mem_we;

    logic     out_free;
    logic     advance;
    logic     last_rnd;
    rnd_idx_t rnd_sel;
    word_t    fx, fy;

    assign out_free = !m_valid_reg || m_ready;
    assign last_rnd = (cnt_reg == LAST_RND);
    assign advance  = !last_rnd || out_free;
    assign mem_we   = (state_reg == ST_EXPAND);
    assign fx       = round_f(x_reg);
    assign fy       = round_f(y_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rk_mem[cnt_reg] <= win_reg[0];
        end
        rk_rdata <= rk_mem[rd_addr];
    end

    always_comb begin
        rnd_sel = advance ? cnt_reg + 5'd1 : cnt_reg;
        case (state_reg)
            ST_IDLE: rd_addr = {RND_IDX_BITS{s_cmd}};
            ST_RUN:  rd_addr = rnd_sel ^ {RND_IDX_BITS{cmd_reg}};
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                KEY_IDX_0: key_reg[0] <= cfg_wr_data;
                KEY_IDX_1: key_reg[1] <= cfg_wr_data;
                KEY_IDX_2: key_reg[2] <= cfg_wr_data;
                KEY_IDX_3: key_reg[3] <= cfg_wr_data;
                default: key_reg[0] <= key_reg[0];
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        keys_ready_next = keys_ready_reg;
        cmd_next        = cmd_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        win_next        = win_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        s_ready         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = keys_ready_reg;
                if (!keys_ready_reg && !cfg_wr_en) begin
                    win_next   = key_reg;
                    cnt_next   = '0;
                    state_next = ST_EXPAND;
                end else if (s_valid && keys_ready_reg) begin
                    cmd_next   = s_cmd;
                    x_next     = s_block_upper;
                    y_next     = s_block_lower;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_EXPAND: begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = key_next(win_reg[0], win_reg[1], win_reg[3],
                                       Z0_SEQ[{1'b0, cnt_reg}]);
                cnt_next    = cnt_reg + 5'd1;
                if (last_rnd) begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    if (!cmd_reg) begin
                        x_next = y_reg ^ fx ^ rk_rdata;
                        y_next = x_reg;
                    end else begin
                        y_next = x_reg ^ fy ^ rk_rdata;
                        x_next = y_reg;
                    end
                    cnt_next = cnt_reg + 5'd1;
                    if (last_rnd) begin
                        out_x_next   = x_next;
                        out_y_next   = y_next;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr_en) begin
            keys_ready_next = 1'b0;
            if (state_reg == ST_EXPAND) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            keys_ready_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            keys_ready_reg <= keys_ready_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        win_reg   <= win_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_upper = out_x_reg;
    assign m_result_lower = out_y_reg;

    `SIMON_ASSERT(a_accept_starts_run,
        (s_valid && s_ready) |=> (state_reg == ST_RUN && cnt_reg == '0))
    `SIMON_ASSERT(a_expand_sets_ready,
        (state_reg == ST_EXPAND && cnt_reg == LAST_RND && !cfg_wr_en) |=> keys_ready_reg)
    `SIMON_ASSERT(a_last_round_delivers,
        (state_reg == ST_RUN && cnt_reg == LAST_RND && out_free)
            |=> (m_valid_reg && state_reg == ST_IDLE))
    `SIMON_ASSERT_ALWAYS(a_no_accept_without_keys,
        (s_ready && aresetn) |-> (keys_ready_reg && state_reg == ST_IDLE))

endmodule
